FILE: rtl/llmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// llmf_pkg
// Shared constants and controller/datapath interface types for the light
// level merge with row flicker.
// ============================================================================
package llmf_pkg;

    // Generator and saturation constants
    localparam logic [31:0] LCG_MUL  = 32'd32310901;
    localparam logic [31:0] LCG_SEED = 32'd213;
    localparam logic [16:0] SAT_SUM  = 17'd64516;
    localparam logic [7:0]  LEVEL_MAX = 8'hFF;

    // Root iterations: one result bit per step
    localparam int          ROOT_STEPS = 8;
    localparam int          CNT_W      = $clog2(ROOT_STEPS);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(ROOT_STEPS - 1);

    // Commands from controller to datapath
    typedef struct packed {
        logic             load_in;   // capture input transfer
        logic             step_lcg;  // advance generator
        logic             load_flk;  // latch row flicker
        logic             load_sq;   // subtract flicker, square both levels
        logic             load_sum;  // sum of squares, saturation flag
        logic             root_step; // one restoring root step
        logic [CNT_W-1:0] bit_idx;   // result bit handled by root_step
        logic             load_out;  // move result into output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic row_start; // captured item starts a row
        logic skip;      // new level at or below flicker: no write
        logic out_free;  // output register can take a result this cycle
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/light_level_merge_flicker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence per item: input capture, then on a row start a generator update
// and flicker latch, then the squares, then, when a write is needed, the sum
// and the eight-step restoring square root that shares one compare-subtract
// unit, then hand-off to the output register. One item at a time: a new
// input is taken only once the previous result enters the output register.
// Reset: synchronous, active low; generator returns to 213, row flicker and
// flicker enable to 0, output register empty.
// ============================================================================
// light_level_merge_flicker_top
// Merges a new light level into a stored level with per-row flicker.
// ============================================================================
module light_level_merge_flicker_top
    import llmf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_wdata,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire  [7:0] i_existing_level,
    input  wire  [7:0] i_new_level,
    input  wire        i_row_start,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [7:0] o_merged_level,
    output logic       o_write_enable
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    llmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and output register
    llmf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_existing_level (i_existing_level),
        .i_new_level      (i_new_level),
        .i_row_start      (i_row_start),
        .i_out_ready      (i_out_ready),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .o_merged_level   (o_merged_level),
        .o_write_enable   (o_write_enable)
    );

endmodule
`default_nettype wire

FILE: rtl/llmf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// llmf_ctrl
// Sequencer for one item: generator update and flicker latch on a row start,
// squares, sum and eight root steps if a write is due, then output hand-off.
// ============================================================================
module llmf_ctrl
    import llmf_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LCG  = 3'd1;
    localparam logic [2:0] S_FLK  = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_ROOT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.bit_idx = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_LCG;
                end
            end
            S_LCG: begin
                if (i_sts.row_start) begin
                    o_cmd.step_lcg = 1'b1;
                    n_state = S_FLK;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_FLK: begin
                o_cmd.load_flk = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.load_sq = 1'b1;
                n_state = i_sts.skip ? S_OUT : S_SUM;
            end
            S_SUM: begin
                o_cmd.load_sum = 1'b1;
                n_cnt   = CNT_TOP;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/llmf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// llmf_dp
// Datapath: generator, flicker register, squarers, restoring square root
// and output register.
// ============================================================================
module llmf_dp
    import llmf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_wdata,
    input  wire  [7:0] i_existing_level,
    input  wire  [7:0] i_new_level,
    input  wire        i_row_start,
    input  wire        i_out_ready,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_out_valid,
    output logic [7:0] o_merged_level,
    output logic       o_write_enable
);

    logic        r_en;
    logic [31:0] r_rand;
    logic [1:0]  r_flk;
    logic [7:0]  r_a, r_b;
    logic        r_rs;
    logic [15:0] r_sq_a, r_sq_b;
    logic        r_we;
    logic [16:0] r_rem;
    logic [7:0]  r_root;
    logic        r_sat;
    logic        r_out_valid;
    logic [7:0]  r_out_level;
    logic        r_out_we;

    logic [31:0] w_lcg;
    logic [7:0]  w_b_sub;
    logic [16:0] w_sum;
    logic [4:0]  w_sh;
    logic [17:0] w_trial;
    logic        w_take;

    // Generator step, flicker subtract
    assign w_lcg   = r_rand * LCG_MUL + 32'd1;
    assign w_b_sub = r_b - {6'd0, r_flk};
    assign w_sum   = {1'b0, r_sq_a} + {1'b0, r_sq_b};

    // Trial value: (root << (k+1)) + (1 << 2k)
    assign w_sh    = {2'd0, i_cmd.bit_idx} + 5'd1;
    assign w_trial = ({10'd0, r_root} << w_sh) + (18'd1 << {1'b0, i_cmd.bit_idx, 1'b0});
    assign w_take  = ({1'b0, r_rem} >= w_trial);

    // Status
    assign o_sts.row_start = r_rs;
    assign o_sts.skip      = (r_b <= {6'd0, r_flk});
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Control state: enable, generator, flicker, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= 1'b0;
            r_rand      <= LCG_SEED;
            r_flk       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_en <= i_cfg_wdata;
            end
            if (i_cmd.step_lcg) begin
                r_rand <= w_lcg;
            end
            if (i_cmd.load_flk) begin
                r_flk <= r_en ? r_rand[17:16] : 2'd0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_a  <= i_existing_level;
            r_b  <= i_new_level;
            r_rs <= i_row_start;
        end
        if (i_cmd.load_sq) begin
            r_sq_a <= {8'd0, r_a} * {8'd0, r_a};
            r_sq_b <= {8'd0, w_b_sub} * {8'd0, w_b_sub};
            r_we   <= !o_sts.skip;
        end
        if (i_cmd.load_sum) begin
            r_rem  <= w_sum;
            r_sat  <= (w_sum >= SAT_SUM);
            r_root <= 8'd0;
        end
        if (i_cmd.root_step && w_take) begin
            r_rem  <= r_rem - w_trial[16:0];
            r_root <= r_root | (8'd1 << i_cmd.bit_idx);
        end
        if (i_cmd.load_out) begin
            r_out_we    <= r_we;
            r_out_level <= !r_we ? r_a : (r_sat ? LEVEL_MAX : r_root);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_merged_level = r_out_level;
    assign o_write_enable = r_out_we;

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: light level merge with row flicker
// Drives pixel transfers with random bursts and gaps while the result side
// stalls on its own pattern. A local model of the generator, row flicker and square
// root predicts results not set by the directed table; all are checked field by field.
// ----------------------------------------------------------------------------
module tb;
    import llmf_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 4;

    // One directed pixel, with an optional enable write before it
    typedef struct packed {
        logic [7:0] ex;
        logic [7:0] nw;
        logic       rs;
        logic       cfg_do;
        logic       cfg_val;
        logic       typed;
        logic [7:0] m;
        logic       we;
    } t_row;

    typedef struct packed {
        logic [7:0] merged;
        logic       we;
    } t_merge;

    localparam int NDIR = 24;
    localparam t_row DIR_ROWS [NDIR] = '{
        // existing, new, row start, cfg write, cfg value, typed, merged, we
        '{8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b1, 8'd0,   1'b0}, // zero new level
        '{8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 1'b1, 8'd255, 1'b1}, // both at max
        '{8'd255, 8'd0,   1'b0, 1'b0, 1'b0, 1'b1, 8'd255, 1'b0}, // no write keeps old
        '{8'd10,  8'd1,   1'b0, 1'b1, 1'b1, 1'b1, 8'd10,  1'b1}, // enabled, no row yet
        '{8'd0,   8'd255, 1'b0, 1'b0, 1'b0, 1'b1, 8'd255, 1'b1},
        '{8'd0,   8'd254, 1'b0, 1'b0, 1'b0, 1'b1, 8'd255, 1'b1}, // sum exactly at limit
        '{8'd0,   8'd253, 1'b0, 1'b0, 1'b0, 1'b1, 8'd253, 1'b1}, // just under limit
        '{8'd3,   8'd4,   1'b0, 1'b0, 1'b0, 1'b1, 8'd5,   1'b1},
        '{8'd0,   8'd1,   1'b0, 1'b0, 1'b0, 1'b1, 8'd1,   1'b1},
        '{8'd200, 8'd3,   1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0}, // first row start
        '{8'd77,  8'd2,   1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd50,  8'd2,   1'b0, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0}, // disabled mid-row
        '{8'd50,  8'd3,   1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd1,   8'd1,   1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 1'b1}, // saturates any flicker
        '{8'd0,   8'd4,   1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   8'd3,   1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   8'd1,   1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd128, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd128, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd1,   8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd180, 8'd179, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] existing_level = '0;
    logic [7:0] new_level = '0;
    logic       row_start = 1'b0;
    logic       out_ready = 1'b0;
    wire        o_in_ready;
    wire        o_out_valid;
    wire  [7:0] o_merged_level;
    wire        o_write_enable;

    // Local copy of block state
    logic [31:0] lcg_state = LCG_SEED;
    logic [1:0]  row_flk = '0;
    logic        flk_en = 1'b0;

    t_merge merge_q[$];
    int     err_cnt = 0;
    int     cycle_cnt = 0;
    int     burst_left = 0;

    light_level_merge_flicker_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_existing_level (existing_level),
        .i_new_level      (new_level),
        .i_row_start      (row_start),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_merged_level   (o_merged_level),
        .o_write_enable   (o_write_enable)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Largest r with r*r <= s
    function automatic logic [7:0] floor_root(input int s);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= s)
            r++;
        return r[7:0];
    endfunction

    // Advances the local state for one pixel and returns its merge
    function automatic t_merge merge_light(input logic [7:0] ex, input logic [7:0] nw,
                                           input logic rs);
        t_merge res;
        int     b;
        int     sum;
        if (rs) begin
            lcg_state = lcg_state * LCG_MUL + 32'd1;
            row_flk   = flk_en ? lcg_state[17:16] : 2'd0;
        end
        b = int'(nw);
        if (b <= int'(row_flk)) begin
            res.merged = ex;
            res.we     = 1'b0;
        end else begin
            b   = b - int'(row_flk);
            sum = int'(ex) * int'(ex) + b * b;
            res.merged = (sum >= int'(SAT_SUM)) ? LEVEL_MAX : floor_root(sum);
            res.we     = 1'b1;
        end
        return res;
    endfunction

    // One pixel transfer; sender may idle between bursts of random length
    task automatic send_pixel(input logic [7:0] ex, input logic [7:0] nw, input logic rs,
                              input logic typed, input t_merge typed_res);
        int     gap;
        t_merge res;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid       <= 1'b1;
        existing_level <= ex;
        new_level      <= nw;
        row_start      <= rs;
        do @(posedge i_clk); while (!o_in_ready);
        res = merge_light(ex, nw, rs);
        merge_q.push_back(typed ? typed_res : res);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain;
        @(negedge i_clk);
        in_valid <= 1'b0;
        burst_left = 0;
        wait (merge_q.size() == 0);
    endtask

    // Enable write while idle
    task automatic write_enable_reg(input logic val);
        drain();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        flk_en = val;
    endtask

    // Result side stall pattern: free-flowing, coin-flip, or long stalls
    int rx_mode = 0;
    int rx_hold = 0;
    int rx_span = 0;
    always @(negedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_span <= $urandom_range(30, 120);
        end else begin
            rx_span <= rx_span - 1;
        end
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            case (rx_mode)
                0: begin
                    out_ready <= 1'b1;
                end
                1: begin
                    out_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if (out_ready) begin
                        out_ready <= 1'b0;
                        rx_hold   <= $urandom_range(1, 12);
                    end else begin
                        out_ready <= 1'b1;
                        rx_hold   <= $urandom_range(0, 3);
                    end
                end
            endcase
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_merge want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (merge_q.size() == 0) begin
                $error("result with nothing expected: merged_level=%0d write_enable=%0d",
                       o_merged_level, o_write_enable);
                err_cnt++;
            end else begin
                want = merge_q.pop_front();
                if (o_merged_level !== want.merged) begin
                    $error("merged_level: expected %0d, got %0d", want.merged, o_merged_level);
                    err_cnt++;
                end
                if (o_write_enable !== want.we) begin
                    $error("write_enable: expected %0d, got %0d", want.we, o_write_enable);
                    err_cnt++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_row       row;
        t_merge     none;
        logic [7:0] ex;
        logic [7:0] nw;
        logic       rs;
        int         kind;
        none = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < NDIR; i++) begin
            row = DIR_ROWS[i];
            if (row.cfg_do)
                write_enable_reg(row.cfg_val);
            send_pixel(row.ex, row.nw, row.rs, row.typed, '{row.m, row.we});
        end

        // Random phases over several enable settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: write_enable_reg(1'b1);
                1: write_enable_reg(1'b0);
                2: write_enable_reg(1'b1);
                default: write_enable_reg(1'($urandom_range(0, 1)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = $urandom_range(0, 19);
                ex   = 8'($urandom_range(0, 255));
                nw   = 8'($urandom_range(0, 255));
                rs   = ($urandom_range(0, 5) == 0);
                if (kind < 3) begin
                    // around the flicker threshold
                    nw = 8'($urandom_range(0, 5));
                end else if (kind < 5) begin
                    // near saturation
                    ex = 8'($urandom_range(170, 255));
                    nw = 8'($urandom_range(170, 255));
                end else if (kind == 5) begin
                    ex = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                end
                send_pixel(ex, nw, rs, 1'b0, none);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
